// File: hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

   // Width of the echo width counter; it saturates at all ones
   localparam int COUNT_BITS = 20;

   // Field widths
   localparam int TIMEOUT_BITS = 20;
   localparam int TICK_BITS    = 8;
   localparam int ELAPSED_BITS = 21;
   localparam int WIDTH_BITS   = 20;
   localparam int DIST_BITS    = 18;
   localparam int STATUS_BITS  = 2;
   localparam int INDEX_BITS   = 2;

   // Distance = width * SOUND_MUL / SOUND_DIV, kept as quotient and remainder
   localparam int SOUND_MUL = 343;
   localparam int SOUND_DIV = 2000;
   localparam int REM_BITS  = $clog2(SOUND_DIV);

   // Register reset values
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(30000);
   localparam logic [TICK_BITS-1:0]    SETTLE_RESET  = TICK_BITS'(2);
   localparam logic [TICK_BITS-1:0]    PULSE_RESET   = TICK_BITS'(10);

   // Register indexes
   localparam logic [INDEX_BITS-1:0] REG_TIMEOUT = INDEX_BITS'(0);
   localparam logic [INDEX_BITS-1:0] REG_SETTLE  = INDEX_BITS'(1);
   localparam logic [INDEX_BITS-1:0] REG_PULSE   = INDEX_BITS'(2);

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_NONE    = STATUS_BITS'(0);
   localparam logic [STATUS_BITS-1:0] ST_DONE    = STATUS_BITS'(1);
   localparam logic [STATUS_BITS-1:0] ST_TIMEOUT = STATUS_BITS'(2);

   // Measurement phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SETTLE = 3'd1,
      PH_PULSE  = 3'd2,
      PH_RISE   = 3'd3,
      PH_FALL   = 3'd4
   } phase_type;

endpackage

// File: hdl/ultrasonic_echo_ranger.sv
// Ultrasonic ranger top level: trigger sequencing, echo timing and distance.
//
// Each accepted item is either a one-microsecond tick carrying the sampled echo
// level or a start command, and gives exactly one result, registered in the
// output register. A new item is taken in every cycle in which the output register
// is empty or its result is being taken, since the phase and counter update for one
// item is combinational logic; a result held back by the sink stalls the input.
// The distance is kept as a running quotient and remainder of width*343/2000, so it
// needs no multiplier or divider. Configuration writes are taken in any cycle and
// should be made while no measurement is running.
module ultrasonic_echo_ranger (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] echo_level, [7:1] zero
   input  logic [0:0]  req_tuser,   // [0] cmd
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] trig_level, [20:1] pulse_width_us,
                                    // [38:21] distance_mm, [39] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int TB = uer_pkg::TICK_BITS;
   localparam int EB = uer_pkg::ELAPSED_BITS;
   localparam int CB = uer_pkg::COUNT_BITS;
   localparam int DB = uer_pkg::DIST_BITS;
   localparam int RB = uer_pkg::REM_BITS;

   // configuration registers
   logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_ff;
   logic [TB-1:0]                    settle_ff;
   logic [TB-1:0]                    pulse_ff;

   // measurement state
   uer_pkg::phase_type phase_ff, phase_in;
   logic [TB-1:0]      ticks_ff, ticks_in;
   logic [EB-1:0]      elapsed_ff, elapsed_in;
   logic [CB-1:0]      width_ff, width_in;
   logic [DB-1:0]      dist_ff, dist_in;
   logic [RB-1:0]      rem_ff, rem_in;

   // result register
   logic                           rsp_valid_ff;
   logic                           trig_ff, trig_in;
   logic [uer_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [uer_pkg::WIDTH_BITS-1:0] rep_width_ff, rep_width_in;
   logic [DB-1:0]                  rep_dist_ff, rep_dist_in;

   logic          accept;
   logic          start;
   logic          echo;
   logic [TB-1:0] ticks_inc;
   logic [EB-1:0] elapsed_inc;
   logic          over_time;
   logic [RB:0]   rem_sum;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign start      = req_tuser[0];
   assign echo       = req_tdata[0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, rep_dist_ff, rep_width_ff, trig_ff};

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= uer_pkg::TIMEOUT_RESET;
         settle_ff  <= uer_pkg::SETTLE_RESET;
         pulse_ff   <= uer_pkg::PULSE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            uer_pkg::REG_TIMEOUT: timeout_ff <= csr_data;
            uer_pkg::REG_SETTLE:  settle_ff  <= csr_data[TB-1:0];
            uer_pkg::REG_PULSE:   pulse_ff   <= csr_data[TB-1:0];
            default: ;
         endcase
      end
   end

   // shared increments and the timeout test
   always_comb begin
      ticks_inc   = ticks_ff + TB'(1);
      elapsed_inc = (elapsed_ff == {EB{1'b1}}) ? elapsed_ff : elapsed_ff + EB'(1);
      over_time   = elapsed_inc > EB'(timeout_ff);
      rem_sum     = {1'b0, rem_ff} + (RB+1)'(uer_pkg::SOUND_MUL);
   end

   // next phase, counters and result for the item at the input
   always_comb begin
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      elapsed_in   = elapsed_ff;
      width_in     = width_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      status_in    = uer_pkg::ST_NONE;
      rep_width_in = '0;
      rep_dist_in  = '0;

      if (start) begin
         // begin a ping from idle, ignore otherwise
         if (phase_ff == uer_pkg::PH_IDLE) begin
            elapsed_in = '0;
            width_in   = '0;
            dist_in    = '0;
            rem_in     = '0;
            ticks_in   = '0;
            phase_in   = (settle_ff == '0) ? uer_pkg::PH_PULSE : uer_pkg::PH_SETTLE;
         end
      end else begin
         unique case (phase_ff)
            uer_pkg::PH_IDLE: ;
            uer_pkg::PH_SETTLE: begin
               ticks_in = ticks_inc;
               if (ticks_inc >= settle_ff) begin
                  phase_in = uer_pkg::PH_PULSE;
                  ticks_in = '0;
               end
            end
            uer_pkg::PH_PULSE: begin
               ticks_in = ticks_inc;
               if (ticks_inc >= pulse_ff || ticks_inc == '0) begin
                  phase_in   = uer_pkg::PH_RISE;
                  ticks_in   = '0;
                  elapsed_in = '0;
                  width_in   = '0;
                  dist_in    = '0;
                  rem_in     = '0;
               end
            end
            uer_pkg::PH_RISE: begin
               elapsed_in = elapsed_inc;
               if (echo) begin
                  // first high tick counts as one microsecond of width
                  phase_in = uer_pkg::PH_FALL;
                  width_in = CB'(1);
                  dist_in  = '0;
                  rem_in   = RB'(uer_pkg::SOUND_MUL);
               end else if (over_time) begin
                  phase_in  = uer_pkg::PH_IDLE;
                  status_in = uer_pkg::ST_TIMEOUT;
               end
            end
            uer_pkg::PH_FALL: begin
               elapsed_in = elapsed_inc;
               if (!echo) begin
                  phase_in     = uer_pkg::PH_IDLE;
                  status_in    = uer_pkg::ST_DONE;
                  rep_width_in = uer_pkg::WIDTH_BITS'(width_ff);
                  rep_dist_in  = dist_ff;
               end else begin
                  // grow width and advance quotient/remainder in step
                  if (width_ff != {CB{1'b1}}) begin
                     width_in = width_ff + CB'(1);
                     if (rem_sum >= (RB+1)'(uer_pkg::SOUND_DIV)) begin
                        rem_in  = RB'(rem_sum - (RB+1)'(uer_pkg::SOUND_DIV));
                        dist_in = dist_ff + DB'(1);
                     end else begin
                        rem_in  = RB'(rem_sum);
                     end
                  end
                  if (over_time) begin
                     phase_in  = uer_pkg::PH_IDLE;
                     status_in = uer_pkg::ST_TIMEOUT;
                  end
               end
            end
            default: phase_in = uer_pkg::PH_IDLE;
         endcase
      end

      trig_in = (phase_in == uer_pkg::PH_PULSE);
   end

   // state update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= uer_pkg::PH_IDLE;
         ticks_ff   <= '0;
         elapsed_ff <= '0;
         width_ff   <= '0;
         dist_ff    <= '0;
         rem_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         elapsed_ff <= elapsed_in;
         width_ff   <= width_in;
         dist_ff    <= dist_in;
         rem_ff     <= rem_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         trig_ff      <= trig_in;
         status_ff    <= status_in;
         rep_width_ff <= rep_width_in;
         rep_dist_ff  <= rep_dist_in;
      end
   end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the ultrasonic echo ranger: predicts each result from the items.
`timescale 1ns / 100ps

module testbench;

   localparam int TOTAL_ITEMS = 1950;
   localparam int QUIET_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                            trig;
      logic [uer_pkg::STATUS_BITS-1:0] status;
      logic [uer_pkg::WIDTH_BITS-1:0]  width;
      logic [uer_pkg::DIST_BITS-1:0]   distance;
   } reading_type;

   // Predicts the ranger's reading for every accepted item and checks the results
   class echo_scoreboard_type;
      logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_limit;
      logic [uer_pkg::TICK_BITS-1:0]    settle_len;
      logic [uer_pkg::TICK_BITS-1:0]    pulse_len;
      uer_pkg::phase_type               stage;
      logic [uer_pkg::TICK_BITS-1:0]    stage_count;
      logic [uer_pkg::ELAPSED_BITS-1:0] since_trigger;
      logic [uer_pkg::COUNT_BITS-1:0]   echo_width;
      reading_type                      expected_readings[$];
      int                               mismatches;

      function new();
         timeout_limit = uer_pkg::TIMEOUT_RESET;
         settle_len    = uer_pkg::SETTLE_RESET;
         pulse_len     = uer_pkg::PULSE_RESET;
         stage         = uer_pkg::PH_IDLE;
         stage_count   = '0;
         since_trigger = '0;
         echo_width    = '0;
         mismatches    = 0;
      endfunction

      function void write_register(logic [uer_pkg::INDEX_BITS-1:0] index,
                                   logic [19:0] value);
         case (index)
            uer_pkg::REG_TIMEOUT: timeout_limit = value[uer_pkg::TIMEOUT_BITS-1:0];
            uer_pkg::REG_SETTLE:  settle_len    = value[uer_pkg::TICK_BITS-1:0];
            uer_pkg::REG_PULSE:   pulse_len     = value[uer_pkg::TICK_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      // Advance the ping sequence by one item and queue the reading it gives
      function void predict_reading(logic cmd, logic echo);
         reading_type r;
         logic [31:0] scaled;
         r.status   = uer_pkg::ST_NONE;
         r.width    = '0;
         r.distance = '0;
         if (cmd) begin
            // a start while busy is dropped and lets no time pass
            if (stage == uer_pkg::PH_IDLE) begin
               since_trigger = '0;
               echo_width    = '0;
               stage_count   = '0;
               if (settle_len == '0) begin
                  stage = uer_pkg::PH_PULSE;
               end else begin
                  stage = uer_pkg::PH_SETTLE;
               end
            end
         end else begin
            case (stage)
               uer_pkg::PH_SETTLE: begin
                  stage_count = stage_count + 8'd1;
                  if (stage_count >= settle_len) begin
                     stage       = uer_pkg::PH_PULSE;
                     stage_count = '0;
                  end
               end
               uer_pkg::PH_PULSE: begin
                  // a zero pulse length ends after one tick, since any count reaches it
                  stage_count = stage_count + 8'd1;
                  if (stage_count >= pulse_len || stage_count == '0) begin
                     stage         = uer_pkg::PH_RISE;
                     stage_count   = '0;
                     since_trigger = '0;
                     echo_width    = '0;
                  end
               end
               uer_pkg::PH_RISE: begin
                  if (since_trigger != '1) since_trigger = since_trigger + 1'b1;
                  if (echo) begin
                     stage      = uer_pkg::PH_FALL;
                     echo_width = uer_pkg::COUNT_BITS'(1);
                  end else if (since_trigger > {1'b0, timeout_limit}) begin
                     stage    = uer_pkg::PH_IDLE;
                     r.status = uer_pkg::ST_TIMEOUT;
                  end
               end
               uer_pkg::PH_FALL: begin
                  if (since_trigger != '1) since_trigger = since_trigger + 1'b1;
                  if (!echo) begin
                     stage      = uer_pkg::PH_IDLE;
                     r.status   = uer_pkg::ST_DONE;
                     scaled     = 32'(echo_width) * 32'(uer_pkg::SOUND_MUL) /
                                  32'(uer_pkg::SOUND_DIV);
                     r.width    = echo_width[uer_pkg::WIDTH_BITS-1:0];
                     r.distance = scaled[uer_pkg::DIST_BITS-1:0];
                  end else begin
                     if (echo_width != '1) echo_width = echo_width + 1'b1;
                     if (since_trigger > {1'b0, timeout_limit}) begin
                        stage    = uer_pkg::PH_IDLE;
                        r.status = uer_pkg::ST_TIMEOUT;
                     end
                  end
               end
               default: stage = uer_pkg::PH_IDLE;
            endcase
         end
         r.trig = (stage == uer_pkg::PH_PULSE);
         expected_readings.push_back(r);
      endfunction

      // Compare one result with the oldest predicted reading
      function void check_reading(logic [39:0] tdata, logic [1:0] tuser);
         reading_type want;
         reading_type got;
         got.trig     = tdata[0];
         got.width    = tdata[20:1];
         got.distance = tdata[38:21];
         got.status   = tuser;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result with no reading waiting: trig %0d status %0d %s %0d %s %0d",
                        got.trig, got.status, "width", got.width, "dist", got.distance);
            return;
         end
         want = expected_readings.pop_front();
         if (got.trig !== want.trig || got.status !== want.status ||
             got.width !== want.width || got.distance !== want.distance) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: expected trig %0d status %0d width %0d dist %0d, %s",
                        want.trig, want.status, want.width, want.distance,
                        $sformatf("got trig %0d status %0d width %0d dist %0d",
                                  got.trig, got.status, got.width, got.distance));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [0] echo_level, [7:1] zero
   logic [0:0]  req_tuser  = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [0] trig_level, [20:1] pulse_width_us, [38:21] distance_mm
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [19:0] csr_data   = '0;

   echo_scoreboard_type board = new();
   bit                  sender_pauses   = 1'b0;
   bit                  receiver_stalls = 1'b0;
   int                  rsp_hold        = 0;
   int                  items_sent      = 0;

   ultrasonic_echo_ranger i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Take results; while receiver_stalls is set, hold ready low for a random pause after each one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_reading(rsp_tdata, rsp_tuser);
            rsp_hold = receiver_stalls ? $urandom_range(0, 6) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Drop the run once no item has moved on any channel for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Offer one item, after a random gap when sender_pauses is set, and wait until it is taken
   task automatic send_item(input logic cmd, input logic echo);
      int gap;
      gap = sender_pauses ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, echo};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.predict_reading(cmd, echo);
      items_sent++;
   endtask

   // Stop offering items and wait for every reading to come back
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [19:0] timeout_val, input logic [7:0] settle_val,
                               input logic [7:0] pulse_val);
      logic [19:0] values [3];
      logic [1:0]  indexes [3];
      values[0]  = timeout_val;
      values[1]  = {12'b0, settle_val};
      values[2]  = {12'b0, pulse_val};
      indexes[0] = uer_pkg::REG_TIMEOUT;
      indexes[1] = uer_pkg::REG_SETTLE;
      indexes[2] = uer_pkg::REG_PULSE;
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[k];
         csr_data  <= values[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.write_register(indexes[k], values[k]);
      end
      csr_valid <= 1'b0;
   endtask

   // Run the trigger out and close any wait with a clean echo
   task automatic settle_down();
      while (board.stage != uer_pkg::PH_IDLE)
         send_item(1'b0, board.stage == uer_pkg::PH_RISE);
   endtask

   // One well-formed ping with random wait and echo lengths, stray starts mixed in
   task automatic run_ping();
      int reach;
      int rise_wait;
      int fall_len;
      reach     = (board.timeout_limit < 50) ? int'(board.timeout_limit) + 3 : 40;
      rise_wait = $urandom_range(0, reach);
      fall_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
                                              : $urandom_range(1, reach);
      send_item(1'b1, 1'($urandom_range(0, 1)));
      while (board.stage == uer_pkg::PH_SETTLE || board.stage == uer_pkg::PH_PULSE)
         send_item($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
      repeat (rise_wait)
         if (board.stage == uer_pkg::PH_RISE) send_item($urandom_range(0, 9) == 0, 1'b0);
      if (board.stage == uer_pkg::PH_RISE) send_item(1'b0, 1'b1);
      repeat (fall_len - 1)
         if (board.stage == uer_pkg::PH_FALL) send_item($urandom_range(0, 9) == 0, 1'b1);
      if (board.stage == uer_pkg::PH_FALL) send_item(1'b0, 1'b0);
   endtask

   // Random items: mostly ticks with a random echo, a few starts
   task automatic run_noise();
      int count;
      count = $urandom_range(5, 30);
      repeat (count) send_item($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int          pings;
      logic [19:0] timeout_val;
      logic [7:0]  settle_val;
      logic [7:0]  pulse_val;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: idle ticks, a busy start, a short echo with a start inside it
      receiver_stalls = 1'b1;
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);
      while (board.stage == uer_pkg::PH_SETTLE || board.stage == uer_pkg::PH_PULSE)
         send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b1);
      send_item(1'b1, 1'b1);
      send_item(1'b0, 1'b0);

      // Zero settle, zero pulse and zero timeout: time out waiting for rise, then for fall
      quiesce();
      write_config(20'd0, 8'd0, 8'd0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b1);

      // Top of every register range
      quiesce();
      write_config(20'hFFFFF, 8'hFF, 8'hFF);
      sender_pauses = 1'b1;
      run_ping();
      settle_down();

      // Random settings, mostly short timings so that timeouts are reached
      while (items_sent < TOTAL_ITEMS) begin
         quiesce();
         case ($urandom_range(0, 7))
            0:       timeout_val = 20'd1;
            1:       timeout_val = 20'hFFFFF;
            2:       timeout_val = 20'($urandom_range(1, 20'hFFFFF));
            default: timeout_val = 20'($urandom_range(1, 60));
         endcase
         case ($urandom_range(0, 9))
            0:       settle_val = 8'hFF;
            1:       settle_val = 8'($urandom_range(0, 255));
            default: settle_val = 8'($urandom_range(0, 4));
         endcase
         case ($urandom_range(0, 9))
            0:       pulse_val = 8'hFF;
            1:       pulse_val = 8'($urandom_range(0, 255));
            default: pulse_val = 8'($urandom_range(0, 5));
         endcase
         write_config(timeout_val, settle_val, pulse_val);
         sender_pauses   = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         pings = (settle_val > 16 || pulse_val > 16) ? 2 : $urandom_range(6, 16);
         repeat (pings)
            if (items_sent < TOTAL_ITEMS) begin
               if ($urandom_range(0, 4) == 0) run_noise();
               else run_ping();
            end
         settle_down();
      end

      quiesce();
      repeat (4) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
